>>> rtl/geq_pkg.sv
// Package: shared constants, payload structs and sequencer state type for the equaliser.
`timescale 1ns / 1ps
package geq_pkg;

    localparam int BANDS    = 10;
    localparam int CHANNELS = 2;
    localparam int SLOTS    = 5;

    localparam int BAND_IW  = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CADDR_W  = $clog2(BANDS * SLOTS);
    localparam int DADDR_W  = (CHANNELS * BANDS > 1) ? $clog2(CHANNELS * BANDS) : 1;

    localparam logic signed [31:0] UNITY_Q28 = 32'sd268435456;

    localparam logic [1:0] OP_LOAD_COEF = 2'd0;
    localparam logic [1:0] OP_LOAD_GAIN = 2'd1;
    localparam logic [1:0] OP_PROCESS   = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [0:0]         channel_index;
        logic [3:0]         band_index;
        logic [2:0]         coef_slot;
        logic signed [31:0] coef_value;
        logic signed [23:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic [0:0]         out_channel;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BAND,
        ST_GAIN,
        ST_OUT
    } t_state;

endpackage

>>> rtl/graphic_eq_biquad_cascade.sv
// Top level: ten-band TDF-II biquad cascade per channel with output gain.
//
//  channel | direction | signals
//  --------+-----------+-----------------------------------------------
//  in      | sink      | i_in_valid, o_in_ready, i_in_data (t_in_item)
//  out     | source    | o_out_valid, i_out_ready, o_out_data (t_out_item)
//
// Load items (coefficient, gain) are taken in idle and give no transfer out.
// A process item runs through the bands in turn on the one shared multiplier
// (five products per band, with the coefficient memory read registered ahead
// of it), then through the gain and output stage.
// Reset clears the valid bits of both memories at once, so entries never
// written read as pass-through coefficients and zero delay state.
// A result waiting in the output register does not block new input items;
// only the final output load stalls until that register frees up.
`timescale 1ns / 1ps
module graphic_eq_biquad_cascade (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  geq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output geq_pkg::t_out_item  o_out_data
);

    localparam int NCOEF = geq_pkg::BANDS * geq_pkg::SLOTS;
    localparam int NDLY  = geq_pkg::CHANNELS * geq_pkg::BANDS;

    // band step numbers
    localparam logic [2:0] STP_B0X  = 3'd2;
    localparam logic [2:0] STP_B1X  = 3'd3;
    localparam logic [2:0] STP_B2X  = 3'd4;
    localparam logic [2:0] STP_A1Y  = 3'd5;
    localparam logic [2:0] STP_LAST = 3'd6;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sh007FFFFFFF;
        lo = -hi - 40'sd1;
        if (v > hi) return 32'sh7FFFFFFF;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sh0_7FFF_FFFF_FFFF;
        lo = -hi - 50'sd1;
        if (v > hi) return 48'sh7FFF_FFFF_FFFF;
        if (v < lo) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sh0007FFFFF;
        lo = -hi - 36'sd1;
        if (v > hi) return 24'sh7FFFFF;
        if (v < lo) return 24'sh800000;
        return v[23:0];
    endfunction

    geq_pkg::t_state r_state, n_state;

    logic [2:0]                     r_step;
    logic [geq_pkg::BAND_IW-1:0]    r_band;
    logic [0:0]                     r_ch;
    logic signed [31:0]             r_x;
    logic signed [31:0]             r_yn;
    logic signed [49:0]             r_acc1;
    logic signed [49:0]             r_acc2;
    logic signed [31:0]             r_gain;
    logic                           r_out_valid;
    geq_pkg::t_out_item             r_out;

    // coefficient memory with per-entry valid bits
    logic signed [31:0]             r_cmem [NCOEF];
    logic [NCOEF-1:0]               r_cval;
    logic signed [31:0]             r_cmem_q;
    logic                           r_cval_q;
    logic                           r_cb0_q;

    // delay memory: {z1, z2} per channel and band
    logic [95:0]                    r_dmem [NDLY];
    logic [NDLY-1:0]                r_dval;
    logic [95:0]                    r_dmem_q;
    logic                           r_dval_q;

    logic                           in_fire;
    logic                           load_ok;
    logic                           proc_ok;
    logic [geq_pkg::CADDR_W-1:0]    c_wr_addr;
    logic [geq_pkg::CADDR_W-1:0]    c_rd_addr;
    logic [2:0]                     rd_slot;
    logic [geq_pkg::DADDR_W-1:0]    d_addr;
    logic signed [31:0]             coef_q;
    logic signed [47:0]             z1;
    logic signed [47:0]             z2;
    logic signed [31:0]             mul_a;
    logic signed [31:0]             mul_b;
    logic signed [63:0]             prod;
    logic signed [44:0]             ps;
    logic signed [48:0]             y;
    logic signed [49:0]             acc2_n;
    logic                           last_band;
    logic                           out_free;
    logic                           use_yn;

    assign in_fire   = i_in_valid && o_in_ready;
    assign load_ok   = (int'(i_in_data.band_index) < geq_pkg::BANDS)
                    && (int'(i_in_data.coef_slot) < geq_pkg::SLOTS);
    assign proc_ok   = (int'(i_in_data.channel_index) < geq_pkg::CHANNELS);
    assign c_wr_addr = geq_pkg::CADDR_W'(int'(i_in_data.band_index) * geq_pkg::SLOTS
                                        + int'(i_in_data.coef_slot));
    assign rd_slot   = (r_step > geq_pkg::SLOT_A2) ? geq_pkg::SLOT_A2 : r_step;
    assign c_rd_addr = geq_pkg::CADDR_W'(int'(r_band) * geq_pkg::SLOTS + int'(rd_slot));
    assign d_addr    = geq_pkg::DADDR_W'(int'(r_ch) * geq_pkg::BANDS + int'(r_band));
    assign last_band = (r_band == geq_pkg::BAND_IW'(geq_pkg::BANDS - 1));
    assign out_free  = !r_out_valid || i_out_ready;

    // unwritten coefficient entries read as pass-through
    assign coef_q = r_cval_q ? r_cmem_q : (r_cb0_q ? geq_pkg::UNITY_Q28 : 32'sd0);
    assign z1     = r_dval_q ? r_dmem_q[95:48] : 48'sd0;
    assign z2     = r_dval_q ? r_dmem_q[47:0]  : 48'sd0;

    // floor shift of the product into the state format, 9 fractional bits beyond the sample scale
    assign ps     = prod[63:19];
    assign y      = 49'(ps) + 49'(z1);
    assign acc2_n = r_acc2 - 50'(ps);

    geq_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            geq_pkg::ST_IDLE: begin
                if (in_fire && i_in_data.opcode == geq_pkg::OP_PROCESS && proc_ok) begin
                    n_state = geq_pkg::ST_BAND;
                end
            end
            geq_pkg::ST_BAND: begin
                if (r_step == STP_LAST && last_band) begin
                    n_state = geq_pkg::ST_GAIN;
                end
            end
            geq_pkg::ST_GAIN: begin
                if (r_step != 3'd0) begin
                    n_state = geq_pkg::ST_OUT;
                end
            end
            geq_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = geq_pkg::ST_IDLE;
                end
            end
            default: n_state = geq_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer; hold the gain product steady while the output stalls
    always_comb begin
        o_in_ready = 1'b0;
        use_yn     = 1'b0;
        mul_a      = coef_q;
        unique case (r_state)
            geq_pkg::ST_IDLE: o_in_ready = 1'b1;
            geq_pkg::ST_BAND: use_yn = (r_step >= STP_B2X);
            geq_pkg::ST_GAIN: mul_a = r_gain;
            geq_pkg::ST_OUT:  mul_a = r_gain;
            default:          o_in_ready = 1'b0;
        endcase
        mul_b = use_yn ? r_yn : r_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= geq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memories: write on a coefficient load or at the last band step, read every cycle
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.opcode == geq_pkg::OP_LOAD_COEF && load_ok) begin
            r_cmem[c_wr_addr] <= i_in_data.coef_value;
        end
        r_cmem_q <= r_cmem[c_rd_addr];
        r_cval_q <= r_cval[c_rd_addr];
        r_cb0_q  <= (rd_slot == geq_pkg::SLOT_B0);
        if (r_state == geq_pkg::ST_BAND && r_step == STP_LAST) begin
            r_dmem[d_addr] <= {sat48(r_acc1), sat48(acc2_n)};
        end
        r_dmem_q <= r_dmem[d_addr];
        r_dval_q <= r_dval[d_addr];
    end

    // valid bits and gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval <= '0;
            r_dval <= '0;
            r_gain <= geq_pkg::UNITY_Q28;
        end else begin
            if (in_fire && i_in_data.opcode == geq_pkg::OP_LOAD_COEF && load_ok) begin
                r_cval[c_wr_addr] <= 1'b1;
            end
            if (in_fire && i_in_data.opcode == geq_pkg::OP_LOAD_GAIN) begin
                r_gain <= i_in_data.coef_value;
            end
            if (r_state == geq_pkg::ST_BAND && r_step == STP_LAST) begin
                r_dval[d_addr] <= 1'b1;
            end
        end
    end

    // step counter and band index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_band <= '0;
        end else begin
            unique case (r_state)
                geq_pkg::ST_IDLE: begin
                    r_step <= '0;
                    r_band <= '0;
                end
                geq_pkg::ST_BAND: begin
                    if (r_step == STP_LAST) begin
                        r_step <= '0;
                        r_band <= last_band ? '0 : r_band + 1'b1;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                geq_pkg::ST_GAIN: r_step <= r_step + 3'd1;
                geq_pkg::ST_OUT:  r_step <= '0;
                default:          r_step <= '0;
            endcase
        end
    end

    // datapath: accumulate the five products of each band
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x  <= 32'(i_in_data.sample_value);
            r_ch <= i_in_data.channel_index;
        end
        if (r_state == geq_pkg::ST_BAND) begin
            case (r_step)
                STP_B0X:  r_yn   <= sat32(y[48:9]);
                STP_B1X:  r_acc1 <= 50'(ps) + 50'(z2);
                STP_B2X:  r_acc2 <= 50'(ps);
                STP_A1Y:  r_acc1 <= r_acc1 - 50'(ps);
                STP_LAST: r_x    <= r_yn;
                default:  r_acc2 <= r_acc2;
            endcase
        end
    end

    // output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == geq_pkg::ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == geq_pkg::ST_OUT && out_free) begin
            r_out.sample_out  <= sat24(prod[63:28]);
            r_out.out_channel <= r_ch;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == geq_pkg::ST_BAND |-> r_step <= STP_LAST)
        else $error("band step past last");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == geq_pkg::ST_BAND |-> int'(r_band) < geq_pkg::BANDS)
        else $error("band index out of range");

    a_proc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.opcode == geq_pkg::OP_PROCESS && proc_ok)
        |=> (r_state == geq_pkg::ST_BAND && r_band == '0 && r_step == '0))
        else $error("process item did not start the band sequence");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == geq_pkg::ST_OUT && out_free) |=> (o_out_valid
        && r_state == geq_pkg::ST_IDLE))
        else $error("result not presented");
`endif

endmodule

>>> rtl/geq_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
`timescale 1ns / 1ps
module geq_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

>>> dv/geq_checker.sv
// Checker: watches both channels, predicts the equaliser output and compares.
`timescale 1ns / 1ps
module geq_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  geq_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  geq_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);
    import geq_pkg::*;

    logic signed [31:0] coefs [BANDS*SLOTS];
    logic signed [31:0] gain_q28;
    logic signed [47:0] z1_state [CHANNELS*BANDS];
    logic signed [47:0] z2_state [CHANNELS*BANDS];
    t_out_item          expected_samples [$];

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Run one sample through every band of its channel and update the delay state.
    function automatic t_out_item filter_sample(input t_in_item it);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] yn;
        logic signed [63:0] z1n;
        logic signed [63:0] z2n;
        int                 k;
        t_out_item          r;
        x = 64'(it.sample_value);
        for (int b = 0; b < BANDS; b++) begin
            k = int'(it.channel_index) * BANDS + b;
            y = ((64'(coefs[b*SLOTS]) * x) >>> 19) + 64'(z1_state[k]);
            yn = clamp(y >>> 9, 32);
            z1n = ((64'(coefs[b*SLOTS+1]) * x) >>> 19)
                - ((64'(coefs[b*SLOTS+3]) * yn) >>> 19) + 64'(z2_state[k]);
            z2n = ((64'(coefs[b*SLOTS+2]) * x) >>> 19)
                - ((64'(coefs[b*SLOTS+4]) * yn) >>> 19);
            z1_state[k] = 48'(clamp(z1n, 48));
            z2_state[k] = 48'(clamp(z2n, 48));
            x = yn;
        end
        r.sample_out  = 24'(clamp((64'(gain_q28) * x) >>> 28, 24));
        r.out_channel = it.channel_index;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < BANDS*SLOTS; i++) coefs[i] = (i % SLOTS == 0) ? UNITY_Q28 : '0;
            for (int i = 0; i < CHANNELS*BANDS; i++) begin
                z1_state[i] = '0;
                z2_state[i] = '0;
            end
            gain_q28 = UNITY_Q28;
            expected_samples.delete();
            o_fail_count   <= 0;
            o_results_seen <= 0;
            o_pending      <= 0;
        end else begin
            // compare the output transfer before queuing anything from this edge
            if (i_out_valid && i_out_ready) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_samples.size() == 0) begin
                    $error("unexpected output sample %0d", i_out_data.sample_out);
                    errs++;
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample_out !== i_out_data.sample_out) begin
                        $error("sample_out expected %0d got %0d",
                               want.sample_out, i_out_data.sample_out);
                        errs++;
                    end
                    if (want.out_channel !== i_out_data.out_channel) begin
                        $error("out_channel expected %0d got %0d",
                               want.out_channel, i_out_data.out_channel);
                        errs++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.opcode)
                    OP_LOAD_COEF:
                        if (i_in_data.band_index < BANDS && i_in_data.coef_slot <= SLOT_A2)
                            coefs[int'(i_in_data.band_index)*SLOTS
                                  + int'(i_in_data.coef_slot)] = i_in_data.coef_value;
                    OP_LOAD_GAIN: gain_q28 = i_in_data.coef_value;
                    OP_PROCESS:
                        if (i_in_data.channel_index < CHANNELS)
                            expected_samples.push_back(filter_sample(i_in_data));
                    default: ;
                endcase
            end
            o_fail_count <= o_fail_count + errs;
            o_pending    <= expected_samples.size();
        end
    end
endmodule

>>> dv/graphic_eq_biquad_cascade_tb.sv
// Testbench top: stimulus, idling pattern and verdict for the equaliser cascade.
`timescale 1ns / 1ps
module graphic_eq_biquad_cascade_tb;
    import geq_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        items_sent = 0;
    int        gap_pct = 0;      // sender idle chance in percent
    int        hold_pct = 0;     // receiver idle chance in percent
    bit        long_hold = 1'b0; // request a long receiver hold-off
    int        idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    graphic_eq_biquad_cascade dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    geq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (long_hold) begin
            out_ready <= 1'b0;
            repeat (600) @(posedge i_clk);
            long_hold <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= hold_pct);
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Offer one item and hold it until transferred; idle first at the current rate.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid after the final transfer and hold the input idle until no result is pending.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] op, input int ch, input int band,
                                           input int slot, input int coef, input int smp);
        t_in_item it;
        it.opcode        = op;
        it.channel_index = 1'(ch);
        it.band_index    = 4'(band);
        it.coef_slot     = 3'(slot);
        it.coef_value    = 32'(coef);
        it.sample_value  = 24'(smp);
        return it;
    endfunction

    // Gentle coefficient: near unity for b0, small elsewhere, keeps the cascade alive.
    function automatic int mild_coef(input int slot);
        if (slot == 0) return 268435456 + $signed($urandom_range(0, 1 << 27)) - (1 << 26);
        return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it = t_in_item'(66'({$urandom(), $urandom(), $urandom()}));
        pick = $urandom_range(99);
        if (pick < 70) begin
            it.opcode = OP_PROCESS;
        end else if (pick < 88) begin
            it.opcode = OP_LOAD_COEF;
            if ($urandom_range(9) != 0) begin
                it.band_index = 4'($urandom_range(BANDS - 1));
                it.coef_slot  = 3'($urandom_range(4));
                if ($urandom_range(3) != 0) it.coef_value = mild_coef(int'(it.coef_slot));
            end
        end else if (pick < 96) begin
            it.opcode = OP_LOAD_GAIN;
            if ($urandom_range(3) != 0)
                it.coef_value = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
        end else begin
            it.opcode = 2'd3; // unused opcode, ignored by the block
        end
        return it;
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pass-through extremes, loads at the address limits, special cases
        send_item(make_item(OP_PROCESS, 0, 0, 0, 0, 8388607));
        send_item(make_item(OP_PROCESS, 1, 0, 0, 0, -8388608));
        send_item(make_item(OP_PROCESS, 0, 0, 0, 0, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 15, 7, -1, 0));      // bad band and slot
        send_item(make_item(OP_LOAD_COEF, 0, 3, 5, 12345, 0));    // slot past a2
        send_item(make_item(OP_LOAD_COEF, 0, 10, 0, 0, 0));       // band past the end
        send_item(make_item(2'd3, 1, 2, 1, 777, -5));             // unused opcode
        send_item(make_item(OP_LOAD_COEF, 0, 0, 0, 2147483647, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 9, 4, -2147483648, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 4, 1, 1 << 26, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 4, 2, -(1 << 25), 0));
        send_item(make_item(OP_LOAD_COEF, 0, 4, 3, 1 << 27, 0));
        send_item(make_item(OP_PROCESS, 0, 0, 0, 0, 8388607));
        send_item(make_item(OP_PROCESS, 0, 0, 0, 0, -8388608));
        send_item(make_item(OP_LOAD_GAIN, 0, 0, 0, -2147483648, 0));
        send_item(make_item(OP_PROCESS, 1, 0, 0, 0, 8388607));
        send_item(make_item(OP_LOAD_GAIN, 0, 0, 0, 2147483647, 0));
        send_item(make_item(OP_PROCESS, 1, 0, 0, 0, -1));
        send_item(make_item(OP_LOAD_GAIN, 0, 0, 0, 0, 0));
        send_item(make_item(OP_PROCESS, 0, 0, 0, 0, 4000000));
        send_item(make_item(OP_LOAD_GAIN, 0, 0, 0, UNITY_Q28, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 0, 0, UNITY_Q28, 0));
        send_item(make_item(OP_LOAD_COEF, 0, 9, 4, 0, 0));
        send_item(make_item(OP_PROCESS, 1, 0, 0, 0, 1));
        drain_results();

        // random phases: receiver-heavy idling, then sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct  = (phase == 0) ? 38 : ((phase == 1) ? 76 : 0);
            hold_pct = (phase == 0) ? 76 : ((phase == 1) ? 38 : 0);
            for (int n = 0; n < 375; n++) begin
                if (phase == 2 && n == 50) long_hold <= 1'b1; // fill up and stall input
                if (n == 200) drain_results();                 // pause until all results in
                send_item(random_item());
            end
        end
        drain_results();

        $display("Run covered %0d input items and %0d checked output samples,",
                 items_sent, results_seen);
        $display("with coefficient, gain and ignored loads under mixed back-pressure.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
